@@ hdl/besc_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// besc_pkg
// Shared types and constants of the bouncing eye LED scanner.
// ---------------------------------------------------------------------------
package besc_pkg;

  localparam int EYE_WIDTH_DEFAULT    = 11;
  localparam int TRACK_LENGTH_DEFAULT = 35;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFF_HOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONCE_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] OFF_HOLD_RESET   = 12'd500;
  localparam logic [CFG_W-1:0] ONCE_MIN_RESET   = 12'd200;
  localparam logic [CFG_W-1:0] HOLD_LIMIT_RESET = 12'd2000;
  localparam logic [CFG_W-1:0] COUNT_MAX        = 12'hFFF;

  // floor(b / 7) for an 8-bit b equals (b * 293) >> 11.
  localparam logic [8:0] DIV7_MUL   = 9'd293;
  localparam int         DIV7_SHIFT = 11;
  localparam int         DEC_W      = 6;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_ONCE = 2'd2
  } run_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic       button_down;
    logic [7:0] brightness;
    logic [7:0] step_interval;
  } tick_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic       frame_last;
  } pixel_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_pixel;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hdl/besc_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// besc_ctrl
// Sequencer: takes a tick, runs the state update, then walks the frame.
// ---------------------------------------------------------------------------
module besc_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    tick_valid,
  output logic                   tick_stall,
  input  besc_pkg::dp_status_t   status,
  output besc_pkg::ctrl_cmd_t    cmd
);

  besc_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= besc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      besc_pkg::ST_IDLE: begin
        if (tick_valid) begin
          state_next = besc_pkg::ST_UPDATE;
        end
      end
      besc_pkg::ST_UPDATE: begin
        state_next = besc_pkg::ST_EMIT;
      end
      besc_pkg::ST_EMIT: begin
        if (status.out_free && status.last_pixel) begin
          state_next = besc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = besc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tick_stall  = 1'b1;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state)
      besc_pkg::ST_IDLE: begin
        tick_stall  = 1'b0;
        cmd.capture = tick_valid;
      end
      besc_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      besc_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        tick_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/besc_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// besc_datapath
// Mode, button and eye state, the eye image description and the pixel
// generator with its output register.
// ---------------------------------------------------------------------------
module besc_datapath #(
  parameter int EYE_WIDTH    = besc_pkg::EYE_WIDTH_DEFAULT,
  parameter int TRACK_LENGTH = besc_pkg::TRACK_LENGTH_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [besc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [besc_pkg::CFG_W-1:0]          cfg_data,
  input  besc_pkg::tick_t                    tick,
  input  besc_pkg::ctrl_cmd_t                cmd,
  output besc_pkg::dp_status_t               status,
  output logic                               pixel_valid,
  input  wire                                pixel_stall,
  output besc_pkg::pixel_t                   pixel
);

  localparam int HALF_EYE = (EYE_WIDTH + 1) / 2;
  localparam int POS_W    = $clog2(TRACK_LENGTH + 1);
  localparam int CTR_W    = $clog2(EYE_WIDTH + 1);
  localparam int N_W      = $clog2(TRACK_LENGTH + EYE_WIDTH + 1);
  localparam int DEC_W    = besc_pkg::DEC_W;
  localparam int PROD_W   = CTR_W + DEC_W;
  localparam int CW       = besc_pkg::CFG_W;

  localparam logic [POS_W-1:0] TRACK_END  = POS_W'(TRACK_LENGTH);
  localparam logic [CTR_W-1:0] EYE_SPAN   = CTR_W'(EYE_WIDTH);
  localparam logic [CTR_W-1:0] HALF_SPAN  = CTR_W'(HALF_EYE);
  localparam logic [N_W-1:0]   LAST_PLAIN = N_W'(TRACK_LENGTH);
  localparam logic [N_W-1:0]   LAST_EYE   = N_W'(TRACK_LENGTH + EYE_WIDTH);
  localparam logic [N_W-1:0]   EYE_COUNT  = N_W'(EYE_WIDTH);

  // Configuration registers.
  logic [CW-1:0] off_hold;
  logic [CW-1:0] once_min;
  logic [CW-1:0] hold_limit;

  // Scanner state.
  besc_pkg::tick_t     tick_reg;
  besc_pkg::run_mode_t run_mode;
  logic                press_held;
  logic [CW-1:0]       hold_count;
  logic [POS_W-1:0]    eye_pos;
  logic                moving_down;
  logic [7:0]          elapsed_ticks;

  // The eye image is kept as its generating terms.
  logic                img_on;
  logic [7:0]          img_bright;
  logic [DEC_W-1:0]    img_dec;
  logic [CTR_W-1:0]    img_centre;

  logic [N_W-1:0]      emit_count;

  // Update terms.
  logic [7:0]          elapsed_inc;
  logic [CW-1:0]       count_inc;
  logic [CW-1:0]       end_cnt;
  logic                ending;
  logic                counting;
  logic                move;
  besc_pkg::run_mode_t mode_b;
  besc_pkg::run_mode_t mode_next;
  logic                held_next;
  logic [CW-1:0]       count_next;
  logic [POS_W-1:0]    pos_b;
  logic [POS_W-1:0]    pos_next;
  logic [POS_W:0]      step_pos;
  logic [POS_W-1:0]    remaining;
  logic                down_next;
  logic [7:0]          elapsed_next;
  logic [CTR_W-1:0]    centre_next;
  logic [16:0]         dec_prod;
  logic [DEC_W-1:0]    dec_next;

  // Pixel terms.
  logic                has_eye;
  logic [N_W-1:0]      last_index;
  logic [N_W-1:0]      rel;
  logic                in_eye;
  logic [CTR_W-1:0]    img_idx;
  logic [CTR_W-1:0]    eye_dist;
  logic [PROD_W-1:0]   prod;
  logic                lit;
  logic [7:0]          red;
  logic                load;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_hold   <= besc_pkg::OFF_HOLD_RESET;
      once_min   <= besc_pkg::ONCE_MIN_RESET;
      hold_limit <= besc_pkg::HOLD_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        besc_pkg::REG_OFF_HOLD:   off_hold   <= cfg_data;
        besc_pkg::REG_ONCE_MIN:   once_min   <= cfg_data;
        besc_pkg::REG_HOLD_LIMIT: hold_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tick_reg <= tick;
    end
  end

  // Button handling, then the eye step, as one update per tick.
  always_comb begin
    elapsed_inc = (elapsed_ticks == 8'hFF) ? elapsed_ticks : elapsed_ticks + 8'd1;
    count_inc   = (hold_count == besc_pkg::COUNT_MAX) ? hold_count : hold_count + 12'd1;
    mode_b      = run_mode;
    held_next   = press_held;
    count_next  = hold_count;
    pos_b       = eye_pos;
    elapsed_next = elapsed_inc;
    counting    = 1'b0;
    ending      = 1'b0;
    end_cnt     = hold_count;

    priority if (press_held) begin
      held_next = tick_reg.button_down;
    end else if (!tick_reg.button_down) begin
      ending = (hold_count != '0);
    end else if (run_mode == besc_pkg::MODE_ON && count_inc > off_hold) begin
      mode_b     = besc_pkg::MODE_OFF;
      held_next  = 1'b1;
      count_next = '0;
    end else if (count_inc >= hold_limit) begin
      ending  = 1'b1;
      end_cnt = count_inc;
    end else begin
      count_next = count_inc;
      counting   = 1'b1;
    end

    if (ending) begin
      mode_b = (end_cnt > once_min && end_cnt < hold_limit) ?
               besc_pkg::MODE_ONCE : besc_pkg::MODE_ON;
      elapsed_next = '0;
      pos_b        = '0;
      held_next    = 1'b1;
      count_next   = '0;
    end

    move = !counting && (elapsed_next > tick_reg.step_interval);

    // Near either end of the track the image is shifted so the eye enters
    // and leaves the strip gradually.
    remaining = TRACK_END - pos_b;
    if (int'(pos_b) < HALF_EYE) begin
      centre_next = CTR_W'(pos_b);
    end else if (int'(remaining) < HALF_EYE) begin
      centre_next = EYE_SPAN - CTR_W'(remaining);
    end else begin
      centre_next = HALF_SPAN;
    end

    dec_prod = 17'(tick_reg.brightness) * 17'(besc_pkg::DIV7_MUL);
    dec_next = DEC_W'(dec_prod >> besc_pkg::DIV7_SHIFT) + DEC_W'(1);

    if (moving_down) begin
      step_pos = (pos_b == '0) ? '0 : {1'b0, pos_b} - (POS_W+1)'(1);
    end else begin
      step_pos = {1'b0, pos_b} + (POS_W+1)'(1);
    end

    mode_next = mode_b;
    down_next = moving_down;
    pos_next  = pos_b;
    if (move) begin
      elapsed_next = '0;
      if (step_pos == '0) begin
        down_next = 1'b0;
        if (mode_b == besc_pkg::MODE_ONCE) begin
          mode_next = besc_pkg::MODE_OFF;
        end
      end
      if (step_pos >= {1'b0, TRACK_END}) begin
        step_pos  = {1'b0, TRACK_END};
        down_next = 1'b1;
      end
      pos_next = step_pos[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= besc_pkg::MODE_ON;
      press_held    <= 1'b0;
      hold_count    <= '0;
      eye_pos       <= '0;
      moving_down   <= 1'b0;
      elapsed_ticks <= '0;
      img_on        <= 1'b0;
    end else if (cmd.update) begin
      run_mode      <= mode_next;
      press_held    <= held_next;
      hold_count    <= count_next;
      eye_pos       <= pos_next;
      moving_down   <= down_next;
      elapsed_ticks <= elapsed_next;
      if (move) begin
        img_on <= (mode_b != besc_pkg::MODE_OFF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && move) begin
      img_bright <= tick_reg.brightness;
      img_dec    <= dec_next;
      img_centre <= centre_next;
    end
  end

  // Frame: spacers before the eye position, the eye image, the remaining
  // spacers and a closing black pixel.
  always_comb begin
    has_eye    = (eye_pos < TRACK_END);
    last_index = has_eye ? LAST_EYE : LAST_PLAIN;
    rel        = emit_count - N_W'(eye_pos);
    in_eye     = has_eye && (emit_count >= N_W'(eye_pos)) && (rel < EYE_COUNT);
    img_idx    = rel[CTR_W-1:0];
    eye_dist   = (img_idx >= img_centre) ? img_idx - img_centre : img_centre - img_idx;
    prod       = PROD_W'(eye_dist) * PROD_W'(img_dec);
    lit        = img_on && in_eye && (int'(eye_dist) < HALF_EYE) &&
                 (PROD_W'(img_bright) > prod);
    red        = lit ? img_bright - prod[7:0] : 8'd0;

    status.out_free   = !pixel_valid || !pixel_stall;
    status.last_pixel = (emit_count == last_index);
    load              = cmd.emit && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_count <= '0;
    end else if (cmd.update) begin
      emit_count <= '0;
    end else if (load) begin
      emit_count <= emit_count + N_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (load) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel.pixel_red  <= red;
      pixel.frame_last <= status.last_pixel;
    end
  end

endmodule
`default_nettype wire

@@ hdl/bouncing_eye_led_scanner_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bouncing_eye_led_scanner_unit
// Bouncing red eye scanner for an LED strip, one frame per millisecond tick.
// ---------------------------------------------------------------------------
// Usage: each transaction on the tick channel carries the button level, the
// eye brightness and the step interval. The block updates mode, press and
// eye state, then sends one strip frame on the pixel channel, one pixel per
// transaction: TRACK_LENGTH + 1 pixels, plus EYE_WIDTH image pixels while
// the eye is on the track (36 or 47 with the default sizes). frame_last
// marks the closing pixel. The cfg port writes the three press timing
// registers; the user must do so only while the block is idle, as the
// block itself does not enforce it.
// Timing: a tick is taken, the update runs in the next cycle and the first
// pixel is loaded into the output register in the emit state.
// The frame then leaves the single output register of the pixel generator
// at one pixel per cycle while the receiver does not stall. tick_stall
// stays high after acceptance until the closing pixel is loaded; the next
// tick may be taken while that pixel still waits. A stall on the pixel
// channel holds the register and pauses the frame. Reset loads the register
// defaults, mode on, eye at position zero and an all-black image.
// ---------------------------------------------------------------------------
module bouncing_eye_led_scanner_unit #(
  parameter int EYE_WIDTH    = besc_pkg::EYE_WIDTH_DEFAULT,
  parameter int TRACK_LENGTH = besc_pkg::TRACK_LENGTH_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            tick_valid,
  output logic                           tick_stall,
  input  besc_pkg::tick_t                tick,
  output logic                           pixel_valid,
  input  wire                            pixel_stall,
  output besc_pkg::pixel_t               pixel,
  input  wire                            cfg_we,
  input  wire [besc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [besc_pkg::CFG_W-1:0]      cfg_data
);

  besc_pkg::ctrl_cmd_t  cmd;
  besc_pkg::dp_status_t status;

  besc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .status     (status),
    .cmd        (cmd)
  );

  besc_datapath #(
    .EYE_WIDTH    (EYE_WIDTH),
    .TRACK_LENGTH (TRACK_LENGTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .tick        (tick),
    .cmd         (cmd),
    .status      (status),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

endmodule
`default_nettype wire

@@ hdl/besc_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// besc_checker
// Port-level checks of the scanner, attached to the top level by bind.
// ---------------------------------------------------------------------------
module besc_checker (
  input wire               clk,
  input wire               rst,
  input wire               tick_valid,
  input wire               tick_stall,
  input wire               pixel_valid,
  input wire               pixel_stall,
  input besc_pkg::pixel_t  pixel
);

  // A stalled pixel is not dropped.
  a_pixel_held: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid)
    else $error("pixel transaction dropped while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel valid after reset");

  // An accepted tick keeps the block busy through update and frame start.
  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && !tick_stall |=> tick_stall ##1 tick_stall)
    else $error("tick accepted while a frame is being prepared");

  // Two closing pixels never follow each other.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && pixel.frame_last |=>
      !(pixel_valid && pixel.frame_last))
    else $error("frame closed twice in a row");

endmodule

bind bouncing_eye_led_scanner_unit besc_checker u_besc_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick_valid),
  .tick_stall  (tick_stall),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel       (pixel)
);
`default_nettype wire
